### hw/rtl/tvss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_pkg - shared types and constants for the two-voice step sequencer
// Register map, configuration bundle, fixed note tracks and pitch table.
// ----------------------------------------------------------------------------
package tvss_pkg;

    // Loop and note range
    localparam int unsigned LOOP_STEPS = 32;
    localparam int unsigned POS_W      = $clog2(LOOP_STEPS);
    localparam int unsigned NOTE_COUNT = 128;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LEN  = 3'd0,
        CFG_LEAD_FADE = 3'd1,
        CFG_BASS_FADE = 3'd2,
        CFG_LEAD_PEAK = 3'd3,
        CFG_BASS_PEAK = 3'd4
    } t_cfg_idx;

    // Reset values of the registers
    localparam logic [15:0] RST_STEP_LEN  = 16'd5142;
    localparam logic [15:0] RST_LEAD_FADE = 16'd65515;
    localparam logic [15:0] RST_BASS_FADE = 16'd65530;
    localparam logic [14:0] RST_LEAD_PEAK = 15'd11000;
    localparam logic [14:0] RST_BASS_PEAK = 15'd9000;

    // Configuration bundle handed to the core
    typedef struct packed {
        logic [15:0] step_len;
        logic [15:0] lead_fade;
        logic [15:0] bass_fade;
        logic [14:0] lead_peak;
        logic [14:0] bass_peak;
    } t_cfg;

    // Waveform constants
    localparam logic signed [15:0] PULSE_HI = 16'sd32767;
    localparam logic signed [15:0] PULSE_LO = -16'sd32768;
    localparam logic signed [15:0] TRI_STEP = 16'sd2184;

    // Track entry: hold, rest, or start a note from the pitch table
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_REST = 2'd1,
        CMD_NOTE = 2'd2
    } t_cmd;

    localparam int unsigned SLOT_COUNT = 12;
    localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);

    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
    } t_step;

    // Note numbers the tracks use, one per pitch slot
    localparam int unsigned SLOT_NOTE [SLOT_COUNT] = '{
        48, 53, 55, 72, 76, 77, 79, 81, 83, 84, 86, 88
    };

    // One octave (notes 69..80) in nanohertz
    localparam logic [63:0] NOTE_NHZ [12] = '{
        64'd440000000000, 64'd466163761518, 64'd493883301256, 64'd523251130601,
        64'd554365261954, 64'd587329535835, 64'd622253967444, 64'd659255113826,
        64'd698456462866, 64'd739988845423, 64'd783990871963, 64'd830609395160
    };

    localparam t_step SH = '{cmd: CMD_HOLD, slot: 4'd0};
    localparam t_step SR = '{cmd: CMD_REST, slot: 4'd0};

    // Lead track: slots 3=72 4=76 5=77 6=79 7=81 8=83 9=84 10=86 11=88
    localparam t_step LEAD_SEQ [LOOP_STEPS] = '{
        '{CMD_NOTE, 4'd3},  SH, '{CMD_NOTE, 4'd4},  SH,
        '{CMD_NOTE, 4'd6},  SH, '{CMD_NOTE, 4'd9},  SH,
        '{CMD_NOTE, 4'd8},  '{CMD_NOTE, 4'd9}, '{CMD_NOTE, 4'd10}, SH,
        '{CMD_NOTE, 4'd11}, SH, SH, SH,
        '{CMD_NOTE, 4'd9},  SH, '{CMD_NOTE, 4'd7},  SH,
        '{CMD_NOTE, 4'd5},  SH, '{CMD_NOTE, 4'd6},  SH,
        '{CMD_NOTE, 4'd4},  SH, '{CMD_NOTE, 4'd3},  SH,
        SR, SH, SH, SH
    };

    // Bass track: slots 0=48 1=53 2=55
    localparam t_step BASS_SEQ [LOOP_STEPS] = '{
        '{CMD_NOTE, 4'd0}, SH, SH, SH, SH, SH, SH, SH,
        '{CMD_NOTE, 4'd2}, SH, SH, SH, SH, SH, SH, SH,
        '{CMD_NOTE, 4'd1}, SH, SH, SH, SH, SH, SH, SH,
        '{CMD_NOTE, 4'd2}, SH, SH, SH, '{CMD_NOTE, 4'd0}, SH, SH, SH
    };

endpackage

### hw/rtl/tvss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_if - valid/ready channels of the step sequencer
// Sample request, sample result and register write channels.
// ----------------------------------------------------------------------------

// Sample request
interface tvss_req_if;
    logic valid;
    logic ready;
    logic last_in_buffer;

    modport source (output valid, output last_in_buffer, input ready);
    modport sink   (input valid, input last_in_buffer, output ready);
endinterface

// Sample result
interface tvss_smp_if;
    logic        valid;
    logic        ready;
    logic [31:0] stereo_word;
    logic        buffer_end;

    modport source (output valid, output stereo_word, output buffer_end, input ready);
    modport sink   (input valid, input stereo_word, input buffer_end, output ready);
endinterface

// Register write
interface tvss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/tvss_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_cfg - configuration registers
// Takes register writes; unlisted indexes are dropped.
// ----------------------------------------------------------------------------
module tvss_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tvss_cfg_if.sink        i_cfg,
    output tvss_pkg::t_cfg  o_cfg
);
    import tvss_pkg::*;

    t_cfg r_cfg;

    // Writes are always accepted
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_len  <= RST_STEP_LEN;
            r_cfg.lead_fade <= RST_LEAD_FADE;
            r_cfg.bass_fade <= RST_BASS_FADE;
            r_cfg.lead_peak <= RST_LEAD_PEAK;
            r_cfg.bass_peak <= RST_BASS_PEAK;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STEP_LEN:  r_cfg.step_len  <= i_cfg.data;
                CFG_LEAD_FADE: r_cfg.lead_fade <= i_cfg.data;
                CFG_BASS_FADE: r_cfg.bass_fade <= i_cfg.data;
                CFG_LEAD_PEAK: r_cfg.lead_peak <= i_cfg.data[14:0];
                CFG_BASS_PEAK: r_cfg.bass_peak <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

endmodule

### hw/rtl/tvss_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_mul - shared signed multiplier
// One 33x17 signed multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
module tvss_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_op_a,
    input  logic signed [16:0] i_op_b,
    output logic signed [49:0] o_prod
);

    logic signed [49:0] r_prod;

    assign o_prod = r_prod;

    // Product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_op_a * i_op_b;
        end
    end

endmodule

### hw/rtl/tvss_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_core - sequencer and voice datapath
// Steps the note tracks, runs both voices through the shared multiplier,
// mixes, saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module tvss_core #(
    parameter int unsigned SAMPLE_RATE = 48000
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tvss_pkg::t_cfg i_cfg,
    tvss_req_if.sink       i_req,
    tvss_smp_if.source     o_smp
);
    import tvss_pkg::*;

    // Pitch table, built at elaboration for the sample rate
    localparam logic [63:0] RateNhz = 64'(SAMPLE_RATE) * 64'd1000000000;

    typedef logic [31:0] t_inc_tab [SLOT_COUNT];

    function automatic logic [31:0] f_pitch_step(input int unsigned note);
        int unsigned u;
        int unsigned oct;
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] r;
        u   = (note % NOTE_COUNT) + 3;
        oct = u / 12;
        a   = NOTE_NHZ[u % 12];
        if (oct >= 6) begin
            a = a << (oct - 6);
        end else begin
            a = a >> (6 - oct);
        end
        q = (a << 16) / RateNhz;
        r = (a << 16) % RateNhz;
        return 32'((q << 16) + ((r << 16) / RateNhz));
    endfunction

    function automatic t_inc_tab f_build_tab();
        t_inc_tab tab;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tab[i] = f_pitch_step(SLOT_NOTE[i]);
        end
        return tab;
    endfunction

    localparam t_inc_tab PITCH_STEP = f_build_tab();

    typedef enum logic [2:0] {
        S_IDLE, S_STEP, S_M0, S_M1, S_M2, S_M3, S_M4, S_OUT
    } t_state;

    t_state             r_state;
    logic [31:0]        r_lead_phase, r_lead_inc, r_lead_env;
    logic [31:0]        r_bass_phase, r_bass_inc, r_bass_env;
    logic [15:0]        r_left;
    logic [POS_W-1:0]   r_pos;
    logic               r_last;
    logic signed [17:0] r_acc;
    logic [15:0]        r_sample;
    logic               r_out_valid;
    logic [31:0]        r_out_word;
    logic               r_out_end;

    logic               mul_en;
    logic signed [32:0] op_a;
    logic signed [16:0] op_b;
    logic signed [49:0] prod;
    logic signed [49:0] prod_sh;
    logic signed [17:0] scaled;
    logic signed [15:0] pulse;
    logic [3:0]         tri_t;
    logic signed [4:0]  tri_k;
    logic signed [15:0] tri_wave;
    t_step              lead_st, bass_st;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_smp.valid       = r_out_valid;
    assign o_smp.stereo_word = r_out_word;
    assign o_smp.buffer_end  = r_out_end;

    // Waveforms from the phase tops
    assign pulse    = (r_lead_phase[31:30] == 2'b00) ? PULSE_HI : PULSE_LO;
    assign tri_t    = r_bass_phase[31] ? ~r_bass_phase[30:27] : r_bass_phase[30:27];
    assign tri_k    = $signed({tri_t, 1'b0}) - 5'sd15;
    assign tri_wave = 16'(tri_k * TRI_STEP);

    // Floor shift of the amplitude product
    assign prod_sh = prod >>> 15;
    assign scaled  = prod_sh[17:0];

    // Track lookup for the current step
    assign lead_st = LEAD_SEQ[r_pos];
    assign bass_st = BASS_SEQ[r_pos];

    // Multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        op_a   = '0;
        op_b   = '0;
        unique case (r_state)
            S_M0: begin
                mul_en = 1'b1;
                op_a   = $signed({17'd0, r_lead_env[31:16]});
                op_b   = 17'(pulse);
            end
            S_M1: begin
                mul_en = 1'b1;
                op_a   = $signed({17'd0, r_bass_env[31:16]});
                op_b   = 17'(tri_wave);
            end
            S_M2: begin
                mul_en = 1'b1;
                op_a   = $signed({1'b0, r_lead_env});
                op_b   = $signed({1'b0, i_cfg.lead_fade});
            end
            S_M3: begin
                mul_en = 1'b1;
                op_a   = $signed({1'b0, r_bass_env});
                op_b   = $signed({1'b0, i_cfg.bass_fade});
            end
            default: ;
        endcase
    end

    tvss_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod)
    );

    // Sequencer, voice state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lead_phase <= '0;
            r_lead_inc   <= '0;
            r_lead_env   <= '0;
            r_bass_phase <= '0;
            r_bass_inc   <= '0;
            r_bass_env   <= '0;
            r_left       <= '0;
            r_pos        <= '0;
            r_last       <= 1'b0;
            r_acc        <= '0;
            r_sample     <= '0;
            r_out_valid  <= 1'b0;
            r_out_word   <= '0;
            r_out_end    <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_out_valid && o_smp.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_last  <= i_req.last_in_buffer;
                        r_state <= S_STEP;
                    end
                end
                // New step: apply track commands and reload the counter; else count down
                S_STEP: begin
                    if (r_left == 16'd0) begin
                        unique case (lead_st.cmd)
                            CMD_REST: r_lead_env <= '0;
                            CMD_NOTE: begin
                                r_lead_phase <= '0;
                                r_lead_inc   <= PITCH_STEP[lead_st.slot];
                                r_lead_env   <= {1'b0, i_cfg.lead_peak, 16'd0};
                            end
                            default: ;
                        endcase
                        unique case (bass_st.cmd)
                            CMD_REST: r_bass_env <= '0;
                            CMD_NOTE: begin
                                r_bass_phase <= '0;
                                r_bass_inc   <= PITCH_STEP[bass_st.slot];
                                r_bass_env   <= {1'b0, i_cfg.bass_peak, 16'd0};
                            end
                            default: ;
                        endcase
                        r_pos  <= r_pos + 1'b1;
                        r_left <= i_cfg.step_len - 16'd1;
                    end else begin
                        r_left <= r_left - 16'd1;
                    end
                    r_state <= S_M0;
                end
                S_M0: r_state <= S_M1;
                // Lead amplitude ready
                S_M1: begin
                    r_acc   <= scaled;
                    r_state <= S_M2;
                end
                // Bass amplitude ready
                S_M2: begin
                    r_acc   <= r_acc + scaled;
                    r_state <= S_M3;
                end
                // Lead envelope decay
                S_M3: begin
                    r_lead_env <= prod[47:16];
                    r_state    <= S_M4;
                end
                // Bass decay, phase advance, saturation
                S_M4: begin
                    r_bass_env   <= prod[47:16];
                    r_lead_phase <= r_lead_phase + r_lead_inc;
                    r_bass_phase <= r_bass_phase + r_bass_inc;
                    if (r_acc > 18'sd32767) begin
                        r_sample <= 16'h7FFF;
                    end else if (r_acc < -18'sd32768) begin
                        r_sample <= 16'h8000;
                    end else begin
                        r_sample <= r_acc[15:0];
                    end
                    r_state <= S_OUT;
                end
                // Load the output register once it is free
                S_OUT: begin
                    if (!r_out_valid || o_smp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= {r_sample, r_sample};
                        r_out_end   <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/two_voice_step_sequencer_synth_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_voice_step_sequencer_synth_top - two-voice step sequencer synthesizer
// Pulse lead and triangle bass from fixed tracks, one stereo sample per request.
//
//   channel  dir  modport  payload
//   i_req    in   sink     last_in_buffer
//   o_smp    out  source   stereo_word[31:0], buffer_end
//   i_cfg    in   sink     index[2:0], data[15:0]
//
// After acceptance a request goes through one step update, four passes through
// the shared 33x17 multiplier, saturation and the output load. A new request
// is taken once the previous one reaches the output register, even while that
// result still waits. A held output register stalls the sequencer in its last
// state. Reset is synchronous and needs no clearing pass; register writes are
// always accepted.
// ----------------------------------------------------------------------------
module two_voice_step_sequencer_synth_top #(
    parameter int unsigned SAMPLE_RATE = 48000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tvss_req_if.sink    i_req,
    tvss_smp_if.source  o_smp,
    tvss_cfg_if.sink    i_cfg
);
    import tvss_pkg::*;

    t_cfg cfg;

    // Register file
    tvss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Sequencer and voices
    tvss_core #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_smp   (o_smp)
    );

endmodule
